@@ sv/bmpw_pkg.sv @@
// Shared types, constants and lookup functions for the RGB565 to BMP stream writer.
package bmpw_pkg;

  localparam int MAX_DIMENSION_DEF = 1024;
  localparam int QUEUE_DEPTH_DEF   = 2;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 2'd1;

  localparam int DIM_REG_W = 11;
  localparam logic [DIM_REG_W-1:0] WIDTH_RESET  = 11'd280;
  localparam logic [DIM_REG_W-1:0] HEIGHT_RESET = 11'd240;

  localparam logic [31:0] BMP_HDR_BYTES = 32'd54;
  localparam logic [31:0] BMP_INFO_SIZE = 32'd40;
  localparam logic [31:0] BMP_PLANES    = 32'd1;
  localparam logic [31:0] BMP_BPP       = 32'd24;
  localparam logic [7:0]  BMP_MAGIC_0   = 8'h42;
  localparam logic [7:0]  BMP_MAGIC_1   = 8'h4D;

  // byte index within the bytes caused by one item
  localparam int IDX_W = 6;
  localparam logic [IDX_W-1:0] IDX_FIRST = 6'd0;
  localparam logic [IDX_W-1:0] IDX_BLUE  = 6'd54;
  localparam logic [IDX_W-1:0] IDX_GREEN = 6'd55;
  localparam logic [IDX_W-1:0] IDX_RED   = 6'd56;

  typedef struct packed {
    logic [15:0] pixel;
    logic        first;
    logic        eof;
  } px_entry_t;

  typedef struct packed {
    logic [31:0] file_size;
    logic [31:0] width;
    logic [31:0] height;
    logic [31:0] data_size;
  } hdr_info_t;

  typedef logic [7:0] scale5_tab_t [32];
  typedef logic [7:0] scale6_tab_t [64];

  function automatic scale5_tab_t build_scale5();
    scale5_tab_t t;
    for (int i = 0; i < 32; i++) begin
      t[i] = 8'((i * 255) / 31);
    end
    return t;
  endfunction

  function automatic scale6_tab_t build_scale6();
    scale6_tab_t t;
    for (int i = 0; i < 64; i++) begin
      t[i] = 8'((i * 255) / 63);
    end
    return t;
  endfunction

  localparam scale5_tab_t SCALE5_TAB = build_scale5();
  localparam scale6_tab_t SCALE6_TAB = build_scale6();

  function automatic logic [7:0] hdr_byte(input logic [IDX_W-1:0] idx, input hdr_info_t h);
    logic [7:0] b;
    unique case (idx)
      6'd0:    b = BMP_MAGIC_0;
      6'd1:    b = BMP_MAGIC_1;
      6'd2:    b = h.file_size[7:0];
      6'd3:    b = h.file_size[15:8];
      6'd4:    b = h.file_size[23:16];
      6'd5:    b = h.file_size[31:24];
      6'd10:   b = BMP_HDR_BYTES[7:0];
      6'd14:   b = BMP_INFO_SIZE[7:0];
      6'd18:   b = h.width[7:0];
      6'd19:   b = h.width[15:8];
      6'd20:   b = h.width[23:16];
      6'd21:   b = h.width[31:24];
      6'd22:   b = h.height[7:0];
      6'd23:   b = h.height[15:8];
      6'd24:   b = h.height[23:16];
      6'd25:   b = h.height[31:24];
      6'd26:   b = BMP_PLANES[7:0];
      6'd28:   b = BMP_BPP[7:0];
      6'd34:   b = h.data_size[7:0];
      6'd35:   b = h.data_size[15:8];
      6'd36:   b = h.data_size[23:16];
      6'd37:   b = h.data_size[31:24];
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

@@ sv/rgb565_bmp24_stream_writer.sv @@
// Top level: RGB565 pixel stream in, 24-bit BMP file byte stream out.
//
//  port group  dir  handshake            carries
//  in_*        in   in_valid/in_stall    in_pixel_rgb565
//  out_*       out  out_valid/out_stall  out_byte, out_last_of_item, out_end_of_frame
//  cfg_*       in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One item yields 3 bytes, 57 with the header; the byte-wide output register emits them
// one at a time, and out_stall holds the current byte in that register.
// An item enters the queue at its accepting edge; the output register then loads its bytes.
// Synchronous active-low reset; image size resets to 280 x 240.
// in_stall is high while the queue is full, during a config write and for one cycle
// after it, and for the first cycle out of reset.
module rgb565_bmp24_stream_writer #(
  parameter int MAX_DIMENSION = bmpw_pkg::MAX_DIMENSION_DEF,
  parameter int QUEUE_DEPTH   = bmpw_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [15:0]                    in_pixel_rgb565,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [7:0]                     out_byte,
  output logic                           out_last_of_item,
  output logic                           out_end_of_frame,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bmpw_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bmpw_pkg::DIM_REG_W-1:0] cfg_data
);
  import bmpw_pkg::*;

  localparam int UD_W  = $clog2(MAX_DIMENSION + 1);
  localparam int TOT_W = 2 * UD_W;
  localparam int DS_W  = TOT_W + 2;

  logic [DIM_REG_W-1:0] width_r, width_nxt;
  logic [DIM_REG_W-1:0] height_r, height_nxt;
  logic                 cfg_we;
  logic                 settle_r;
  logic [UD_W-1:0]      used_w, used_h;
  logic [UD_W-1:0]      used_w_r, used_h_r;
  logic [TOT_W-1:0]     total_r;
  logic [DS_W-1:0]      data_size_r;
  logic [31:0]          file_size_r;
  hdr_info_t            hdr;
  logic                 push, pop, queue_full, head_valid;
  px_entry_t            push_data, head_data;

  function automatic logic [UD_W-1:0] used_dim(input logic [DIM_REG_W-1:0] v);
    logic [UD_W-1:0] r;
    if (v == '0) begin
      r = UD_W'(1);
    end else if (32'(v) > 32'(MAX_DIMENSION)) begin
      r = UD_W'(MAX_DIMENSION);
    end else begin
      r = UD_W'(v);
    end
    return r;
  endfunction

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid & cfg_ready;

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    if (cfg_we && cfg_index == CFG_IDX_WIDTH) begin
      width_nxt = cfg_data;
    end
    if (cfg_we && cfg_index == CFG_IDX_HEIGHT) begin
      height_nxt = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
      settle_r <= 1'b1;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
      settle_r <= cfg_we;
    end
  end

  assign used_w = used_dim(width_r);
  assign used_h = used_dim(height_r);

  // size pipeline: product, then times three, then header offset
  always_ff @(posedge clk) begin
    used_w_r    <= used_w;
    used_h_r    <= used_h;
    total_r     <= used_w * used_h;
    data_size_r <= {total_r, 1'b0} + DS_W'(total_r);
    file_size_r <= 32'(data_size_r) + BMP_HDR_BYTES;
  end

  assign hdr.file_size = file_size_r;
  assign hdr.width     = 32'(used_w_r);
  assign hdr.height    = 32'(used_h_r);
  assign hdr.data_size = 32'(data_size_r);

  bmpw_front #(
    .TOT_W (TOT_W)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_pixel_rgb565 (in_pixel_rgb565),
    .in_stall        (in_stall),
    .total           (total_r),
    .cfg_hold        (cfg_we | settle_r),
    .queue_full      (queue_full),
    .push            (push),
    .push_data       (push_data)
  );

  bmpw_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  (push_data),
    .pop        (pop),
    .full       (queue_full),
    .head_valid (head_valid),
    .head_data  (head_data)
  );

  bmpw_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head_valid       (head_valid),
    .head_data        (head_data),
    .hdr              (hdr),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_byte         (out_byte),
    .out_last_of_item (out_last_of_item),
    .out_end_of_frame (out_end_of_frame)
  );

endmodule

@@ sv/bmpw_queue.sv @@
// Short item queue between the front end and the byte sequencer.
module bmpw_queue #(
  parameter int DEPTH = 2
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  bmpw_pkg::px_entry_t  push_data,
  input  logic                 pop,
  output logic                 full,
  output logic                 head_valid,
  output bmpw_pkg::px_entry_t  head_data
);
  import bmpw_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  px_entry_t        mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full       = (count_r == CNT_FULL);
  assign head_valid = (count_r != '0);
  assign head_data  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> head_valid)
    else $error("queue pop while empty");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n) count_r <= CNT_FULL)
    else $error("queue count out of range");

endmodule

@@ sv/bmpw_front.sv @@
// Front end: accepts pixel items, tracks frame position, marks first and last pixel.
module bmpw_front #(
  parameter int TOT_W = 22
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic [15:0]          in_pixel_rgb565,
  output logic                 in_stall,
  input  logic [TOT_W-1:0]     total,
  input  logic                 cfg_hold,
  input  logic                 queue_full,
  output logic                 push,
  output bmpw_pkg::px_entry_t  push_data
);
  import bmpw_pkg::*;

  logic [TOT_W-1:0] pos_r, pos_nxt;
  logic [TOT_W:0]   pos_inc;
  logic             eof;

  assign in_stall = queue_full | cfg_hold;
  assign push     = in_valid & ~in_stall;
  assign pos_inc  = {1'b0, pos_r} + 1'b1;
  assign eof      = (pos_inc >= {1'b0, total});

  assign push_data.pixel = in_pixel_rgb565;
  assign push_data.first = (pos_r == '0);
  assign push_data.eof   = eof;

  always_comb begin
    pos_nxt = pos_r;
    if (push) begin
      pos_nxt = eof ? '0 : pos_inc[TOT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

endmodule

@@ sv/bmpw_back.sv @@
// Byte sequencer: emits header bytes and the blue, green, red bytes of each item.
module bmpw_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 head_valid,
  input  bmpw_pkg::px_entry_t  head_data,
  input  bmpw_pkg::hdr_info_t  hdr,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [7:0]           out_byte,
  output logic                 out_last_of_item,
  output logic                 out_end_of_frame
);
  import bmpw_pkg::*;

  logic             active_r, active_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [IDX_W-1:0] cur_idx;
  logic             load;
  logic [7:0]       byte_val;
  logic             valid_r, valid_nxt;
  logic [7:0]       byte_r;
  logic             last_r;
  logic             eof_r;

  assign load    = head_valid & (~valid_r | ~out_stall);
  assign cur_idx = active_r ? idx_r : (head_data.first ? IDX_FIRST : IDX_BLUE);
  assign pop     = load & (cur_idx == IDX_RED);

  always_comb begin
    if (cur_idx == IDX_BLUE) begin
      byte_val = SCALE5_TAB[head_data.pixel[4:0]];
    end else if (cur_idx == IDX_GREEN) begin
      byte_val = SCALE6_TAB[head_data.pixel[10:5]];
    end else if (cur_idx == IDX_RED) begin
      byte_val = SCALE5_TAB[head_data.pixel[15:11]];
    end else begin
      byte_val = hdr_byte(cur_idx, hdr);
    end
  end

  always_comb begin
    active_nxt = active_r;
    idx_nxt    = idx_r;
    valid_nxt  = valid_r & out_stall;
    if (load) begin
      valid_nxt  = 1'b1;
      active_nxt = (cur_idx != IDX_RED);
      idx_nxt    = cur_idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      idx_r    <= '0;
      valid_r  <= 1'b0;
    end else begin
      active_r <= active_nxt;
      idx_r    <= idx_nxt;
      valid_r  <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= byte_val;
      last_r <= (cur_idx == IDX_RED);
      eof_r  <= (cur_idx == IDX_RED) & head_data.eof;
    end
  end

  assign out_valid        = valid_r;
  assign out_byte         = byte_r;
  assign out_last_of_item = last_r;
  assign out_end_of_frame = eof_r;

  a_eof_on_last: assert property (@(posedge clk) disable iff (!rst_n)
      valid_r && eof_r |-> last_r)
    else $error("end of frame on a byte that does not end an item");

endmodule
